@@ hdl/slip_frame_decoder_assert.svh @@
// Assertion macros shared by the SLIP frame decoder modules.
`ifndef SLIP_FRAME_DECODER_ASSERT_SVH
`define SLIP_FRAME_DECODER_ASSERT_SVH

// Condition holds at every clock edge outside reset.
`define SFD_ASSERT_ALWAYS(label, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("sfd assertion failed");

// Consequent holds in the same cycle as the antecedent.
`define SFD_ASSERT_IMPLY(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sfd assertion failed");

// Consequent holds in the cycle after the antecedent.
`define SFD_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sfd assertion failed");

`endif

@@ hdl/sfd_pkg.sv @@
// Types and constants shared by the SLIP frame decoder modules.
package sfd_pkg;

	localparam logic [7:0] CODE_END     = 8'o300;
	localparam logic [7:0] CODE_ESC     = 8'o333;
	localparam logic [7:0] CODE_ESC_END = 8'o334;
	localparam logic [7:0] CODE_ESC_ESC = 8'o335;

	localparam logic CMD_RECEIVE = 1'b0;
	localparam logic CMD_READ    = 1'b1;

	localparam logic RESULT_FRAME = 1'b0;
	localparam logic RESULT_READ  = 1'b1;

	typedef enum logic [1:0] {
		OP_WRITE,
		OP_READ,
		OP_END
	} op_kind_t;

	typedef struct packed {
		op_kind_t    kind;
		logic        in_range;
		logic [7:0]  data;
		logic [9:0]  length;
	} op_t;

	typedef struct packed {
		logic        command;
		logic [7:0]  line_byte;
		logic [8:0]  read_index;
	} request_t;

	typedef struct packed {
		logic        result_kind;
		logic [9:0]  frame_length;
		logic [7:0]  read_data;
	} result_t;

endpackage

@@ hdl/sfd_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module sfd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 512,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ hdl/sfd_front.sv @@
// Front end: accepts requests, unescapes line bytes and issues store operations.
`include "slip_frame_decoder_assert.svh"

module sfd_front import sfd_pkg::*; #(
	parameter int STORE_DEPTH = 512,
	localparam int AW = $clog2(STORE_DEPTH)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          request_valid,
	output logic          request_stall,
	input  request_t      request,
	input  logic          q_full,
	output logic          push,
	output op_t           op,
	output logic [AW-1:0] op_addr
);

	localparam int FW = $clog2(STORE_DEPTH + 1);

	logic          esc_q;
	logic [FW-1:0] fill_q;
	logic          accept;
	logic          full;
	logic          end_taken;
	logic [7:0]    stored;
	logic [AW+8:0] idx_wide;
	logic [FW+9:0] fill_wide;

	assign request_stall = q_full;
	assign accept = request_valid && !q_full;
	assign full = (fill_q == FW'(STORE_DEPTH));
	assign end_taken = accept && request.command == CMD_RECEIVE && request.line_byte == CODE_END;
	assign idx_wide = (AW + 9)'(request.read_index);
	assign fill_wide = (FW + 10)'(fill_q);

	always_comb begin
		stored = request.line_byte;
		if (esc_q && request.line_byte == CODE_ESC_END) begin
			stored = CODE_END;
		end else if (esc_q && request.line_byte == CODE_ESC_ESC) begin
			stored = CODE_ESC;
		end
	end

	always_comb begin
		push = 1'b0;
		op = '0;
		op_addr = '0;
		if (accept) begin
			if (request.command == CMD_READ) begin
				push = 1'b1;
				op.kind = OP_READ;
				op.in_range = (32'(request.read_index) < STORE_DEPTH);
				op_addr = idx_wide[AW-1:0];
			end else if (request.line_byte == CODE_END) begin
				push = 1'b1;
				op.kind = OP_END;
				op.length = fill_wide[9:0];
			end else if (request.line_byte != CODE_ESC && !full) begin
				push = 1'b1;
				op.kind = OP_WRITE;
				op.data = stored;
				op_addr = fill_wide[AW-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			esc_q <= 1'b0;
			fill_q <= '0;
		end else if (accept && request.command == CMD_RECEIVE) begin
			if (request.line_byte == CODE_ESC) begin
				esc_q <= 1'b1;
			end else begin
				esc_q <= 1'b0;
				if (request.line_byte == CODE_END || full) begin
					fill_q <= '0;
				end else begin
					fill_q <= fill_q + FW'(1);
				end
			end
		end
	end

	`SFD_ASSERT_ALWAYS(a_fill_bound, fill_q <= FW'(STORE_DEPTH))
	`SFD_ASSERT_NEXT(a_end_clears_fill, end_taken, fill_q == '0)

endmodule

@@ hdl/sfd_queue.sv @@
// Short FIFO that decouples the front end from the back end.
`include "slip_frame_decoder_assert.svh"

module sfd_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	input  logic             pop,
	output logic [WIDTH-1:0] pop_data,
	output logic             full,
	output logic             empty
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] slots_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;

	assign full = (count_q == CW'(DEPTH));
	assign empty = (count_q == '0);
	assign pop_data = slots_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	`SFD_ASSERT_IMPLY(a_no_overflow, count_q == CW'(DEPTH), !push)
	`SFD_ASSERT_IMPLY(a_no_underflow, count_q == '0, !pop)

endmodule

@@ hdl/sfd_back.sv @@
// Back end: carries out store writes and reads and holds the result register.
module sfd_back import sfd_pkg::*; #(
	parameter int STORE_DEPTH = 512,
	localparam int AW = $clog2(STORE_DEPTH)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          q_empty,
	input  op_t           op,
	input  logic [AW-1:0] op_addr,
	output logic          q_pop,
	output logic          result_valid,
	input  logic          result_stall,
	output result_t       result
);

	logic       result_free;
	logic       take;
	logic       ram_we;
	logic       ram_re;
	logic [7:0] ram_rdata;
	logic       valid_s2;
	logic       kind_s2;
	logic       in_range_s2;
	logic [9:0] length_s2;

	assign result_free = !valid_s2 || !result_stall;
	assign q_pop = !q_empty && (op.kind == OP_WRITE || result_free);
	assign take = q_pop && op.kind != OP_WRITE;
	assign ram_we = q_pop && op.kind == OP_WRITE;
	assign ram_re = q_pop && op.kind == OP_READ && op.in_range;

	sfd_ram #(
		.WIDTH(8),
		.DEPTH(STORE_DEPTH)
	) u_store (
		.clk(clk),
		.we(ram_we),
		.waddr(op_addr),
		.wdata(op.data),
		.re(ram_re),
		.raddr(op_addr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (take) begin
			valid_s2 <= 1'b1;
		end else if (!result_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			kind_s2 <= (op.kind == OP_READ) ? RESULT_READ : RESULT_FRAME;
			in_range_s2 <= op.in_range;
			length_s2 <= op.length;
		end
	end

	assign result_valid = valid_s2;

	always_comb begin
		result = '0;
		result.result_kind = kind_s2;
		if (kind_s2 == RESULT_READ) begin
			if (in_range_s2) begin
				result.read_data = ram_rdata;
			end
		end else begin
			result.frame_length = length_s2;
		end
	end

endmodule

@@ hdl/slip_frame_decoder.sv @@
// Top level of the SLIP frame decoder.
// The decoder takes one request per clock while request_stall is low: a line byte to
// unescape into the packet store, or a read of one stored byte. An END byte yields a
// frame-complete result carrying the frame length; a read yields the stored byte, or zero
// when the index is at or beyond STORE_DEPTH. An accepted request is registered in the
// queue, and its result is offered from a register that holds it while the result side
// stalls. The rate is set by the single write and read port of the packet store, which
// the back end uses once per cycle; a four-entry queue between the front and back ends
// absorbs result stalls, since store writes keep draining it while a result waits. The
// store needs no clearing after reset.
module slip_frame_decoder import sfd_pkg::*; #(
	parameter int STORE_DEPTH = 512
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     request_valid,
	output logic     request_stall,
	input  request_t request,
	output logic     result_valid,
	input  logic     result_stall,
	output result_t  result
);

	localparam int AW = $clog2(STORE_DEPTH);
	localparam int QW = $bits(op_t) + AW;
	localparam int QDEPTH = 4;

	logic          f_push;
	op_t           f_op;
	logic [AW-1:0] f_addr;
	logic          q_full;
	logic          q_empty;
	logic          q_pop;
	logic [QW-1:0] q_in;
	logic [QW-1:0] q_out;
	op_t           b_op;
	logic [AW-1:0] b_addr;

	sfd_front #(
		.STORE_DEPTH(STORE_DEPTH)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.request_valid(request_valid),
		.request_stall(request_stall),
		.request(request),
		.q_full(q_full),
		.push(f_push),
		.op(f_op),
		.op_addr(f_addr)
	);

	assign q_in = {f_op, f_addr};

	sfd_queue #(
		.WIDTH(QW),
		.DEPTH(QDEPTH)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(f_push),
		.push_data(q_in),
		.pop(q_pop),
		.pop_data(q_out),
		.full(q_full),
		.empty(q_empty)
	);

	assign b_op = op_t'(q_out[QW-1:AW]);
	assign b_addr = q_out[AW-1:0];

	sfd_back #(
		.STORE_DEPTH(STORE_DEPTH)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.q_empty(q_empty),
		.op(b_op),
		.op_addr(b_addr),
		.q_pop(q_pop),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result)
	);

endmodule

@@ dv/tb_slip_frame_decoder.sv @@
// Self-checking testbench for the SLIP frame decoder: directed table, random frames, predictor.
`timescale 1ns / 1ps

module tb_slip_frame_decoder;
	import sfd_pkg::*;

	localparam int STORE_DEPTH = 512;
	localparam int CYCLE_LIMIT = 200000;
	localparam int LONG_HOLD_CYCLES = 200;
	localparam int RANDOM_TARGET = 780;
	localparam int QUIET_ITEMS = 100;
	localparam int DRAIN_CYCLES = 16;

	typedef struct {
		request_t req;
		bit       typed;
		result_t  expected;
	} directed_row_t;

	logic     clk;
	logic     arst_n;
	logic     request_valid;
	logic     request_stall;
	request_t request;
	logic     result_valid;
	logic     result_stall;
	result_t  result;

	logic [7:0]  last_line_byte;
	int          fill_level;
	int          written_top;
	logic [7:0]  store_copy [STORE_DEPTH];
	result_t     decoded_results [$];
	int          sent;
	int          mismatches;
	int unsigned cycle_count;
	bit          idling;
	bit          hold_requested;

	directed_row_t directed_rows [21];

	slip_frame_decoder #(
		.STORE_DEPTH(STORE_DEPTH)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.request_valid(request_valid),
		.request_stall(request_stall),
		.request(request),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("slip_frame_decoder test failed");
			$finish;
		end
	end

	// Unescapes one request into the shadow store and returns whether it yields a result.
	function automatic bit slip_decode(input request_t r, output result_t res);
		logic [7:0] stored;
		res = '0;
		if (r.command == CMD_READ) begin
			res.result_kind = RESULT_READ;
			res.read_data = (int'(r.read_index) < STORE_DEPTH) ? store_copy[r.read_index] : 8'h00;
			return 1'b1;
		end
		if (r.line_byte == CODE_ESC) begin
			last_line_byte = r.line_byte;
			return 1'b0;
		end
		if (r.line_byte == CODE_END) begin
			last_line_byte = r.line_byte;
			res.result_kind = RESULT_FRAME;
			res.frame_length = 10'(fill_level);
			fill_level = 0;
			return 1'b1;
		end
		stored = r.line_byte;
		if (last_line_byte == CODE_ESC) begin
			if (r.line_byte == CODE_ESC_END)
				stored = CODE_END;
			else if (r.line_byte == CODE_ESC_ESC)
				stored = CODE_ESC;
		end
		last_line_byte = r.line_byte;
		if (fill_level >= STORE_DEPTH) begin
			fill_level = 0;
		end else begin
			store_copy[fill_level] = stored;
			fill_level++;
			if (fill_level > written_top)
				written_top = fill_level;
		end
		return 1'b0;
	endfunction

	task automatic offer_request(input request_t r, input bit typed, input result_t typed_res);
		result_t res;
		bit      has_res;
		if (idling && !hold_requested && $urandom_range(0, 7) == 0) begin
			request_valid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
		request_valid <= 1'b1;
		request <= r;
		do @(posedge clk); while (request_stall);
		has_res = slip_decode(r, res);
		if (typed) begin
			res = typed_res;
			has_res = 1'b1;
		end
		if (has_res)
			decoded_results.push_back(res);
		sent++;
	endtask

	task automatic send_byte(input logic [7:0] b);
		request_t r;
		r.command = CMD_RECEIVE;
		r.line_byte = b;
		r.read_index = 9'($urandom_range(0, 511));
		offer_request(r, 1'b0, '0);
	endtask

	task automatic send_read(input logic [8:0] idx);
		request_t r;
		r.command = CMD_READ;
		r.line_byte = 8'($urandom_range(0, 255));
		r.read_index = idx;
		offer_request(r, 1'b0, '0);
	endtask

	task automatic send_random_read();
		send_read(9'($urandom_range(0, written_top - 1)));
	endtask

	// A well-formed frame of len data bytes, escaped as on the line, closed by END, with reads mixed in.
	task automatic send_frame(input int len);
		logic [7:0] data;
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(0, 5) == 0)
				send_random_read();
			if ($urandom_range(0, 3) == 0) begin
				case ($urandom_range(0, 3))
					0: data = CODE_END;
					1: data = CODE_ESC;
					2: data = CODE_ESC_END;
					default: data = CODE_ESC_ESC;
				endcase
			end else begin
				data = 8'($urandom_range(0, 255));
			end
			if (data == CODE_END) begin
				send_byte(CODE_ESC);
				send_byte(CODE_ESC_END);
			end else if (data == CODE_ESC) begin
				send_byte(CODE_ESC);
				send_byte(CODE_ESC_ESC);
			end else begin
				send_byte(data);
			end
		end
		send_byte(CODE_END);
	endtask

	task automatic send_noise(input int n);
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(0, 3))
				0: send_byte(8'($urandom_range(0, 255)));
				1: send_byte(CODE_ESC);
				2: begin
					send_byte(CODE_ESC);
					send_byte(8'($urandom_range(0, 255)));
				end
				default: begin
					send_byte(CODE_ESC);
					send_byte(CODE_END);
				end
			endcase
		end
	endtask

	task automatic wait_for_results();
		request_valid <= 1'b0;
		do @(posedge clk); while (decoded_results.size() != 0);
	endtask

	always @(posedge clk) begin
		result_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (decoded_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: kind %0d length %0d data %02h",
						result.result_kind, result.frame_length, result.read_data);
			end else begin
				want = decoded_results.pop_front();
				if (result.result_kind !== want.result_kind
						|| result.frame_length !== want.frame_length
						|| result.read_data !== want.read_data) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected %0d/%0d/%02h, got %0d/%0d/%02h",
							want.result_kind, want.frame_length, want.read_data,
							result.result_kind, result.frame_length, result.read_data);
				end
			end
		end
	end

	initial begin : result_side
		int n;
		result_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_requested) begin
				result_stall <= 1'b1;
				repeat (LONG_HOLD_CYCLES) @(posedge clk);
				result_stall <= 1'b0;
				hold_requested = 1'b0;
			end else if (idling && $urandom_range(0, 5) == 0) begin
				n = $urandom_range(1, 18);
				result_stall <= 1'b1;
				repeat (n) @(posedge clk);
				result_stall <= 1'b0;
			end
		end
	end

	initial begin : stimulus
		bit done_hold;
		bit done_pause;
		bit done_overflow;
		logic [7:0] b;
		int quiet_end;
		clk = 1'b0;
		arst_n = 1'b0;
		request_valid = 1'b0;
		request = '0;
		last_line_byte = 8'h00;
		fill_level = 0;
		written_top = 0;
		sent = 0;
		mismatches = 0;
		cycle_count = 0;
		idling = 1'b0;
		hold_requested = 1'b0;
		done_hold = 1'b0;
		done_pause = 1'b0;
		done_overflow = 1'b0;
		quiet_end = 0;

		directed_rows = '{
			'{'{CMD_RECEIVE, CODE_END, 9'h1FF}, 1'b1, '{RESULT_FRAME, 10'd0, 8'h00}},
			'{'{CMD_RECEIVE, CODE_ESC, 9'h000}, 1'b0, '0},
			'{'{CMD_RECEIVE, CODE_ESC_END, 9'h1FF}, 1'b0, '0},
			'{'{CMD_RECEIVE, CODE_ESC, 9'h000}, 1'b0, '0},
			'{'{CMD_RECEIVE, CODE_ESC_ESC, 9'h1FF}, 1'b0, '0},
			'{'{CMD_RECEIVE, CODE_ESC, 9'h000}, 1'b0, '0},
			'{'{CMD_RECEIVE, 8'h41, 9'h1FF}, 1'b0, '0},
			'{'{CMD_RECEIVE, 8'h00, 9'h000}, 1'b0, '0},
			'{'{CMD_RECEIVE, 8'hFF, 9'h1FF}, 1'b0, '0},
			'{'{CMD_RECEIVE, CODE_ESC_END, 9'h000}, 1'b0, '0},
			'{'{CMD_RECEIVE, CODE_ESC_ESC, 9'h1FF}, 1'b0, '0},
			'{'{CMD_RECEIVE, CODE_ESC, 9'h000}, 1'b0, '0},
			'{'{CMD_RECEIVE, CODE_END, 9'h1FF}, 1'b1, '{RESULT_FRAME, 10'd7, 8'h00}},
			'{'{CMD_RECEIVE, CODE_END, 9'h000}, 1'b1, '{RESULT_FRAME, 10'd0, 8'h00}},
			'{'{CMD_READ, 8'hFF, 9'd0}, 1'b1, '{RESULT_READ, 10'd0, 8'hC0}},
			'{'{CMD_READ, 8'h00, 9'd1}, 1'b1, '{RESULT_READ, 10'd0, 8'hDB}},
			'{'{CMD_READ, 8'hFF, 9'd2}, 1'b1, '{RESULT_READ, 10'd0, 8'h41}},
			'{'{CMD_READ, 8'h00, 9'd3}, 1'b1, '{RESULT_READ, 10'd0, 8'h00}},
			'{'{CMD_READ, 8'hFF, 9'd4}, 1'b1, '{RESULT_READ, 10'd0, 8'hFF}},
			'{'{CMD_READ, 8'h00, 9'd5}, 1'b1, '{RESULT_READ, 10'd0, 8'hDC}},
			'{'{CMD_READ, 8'hFF, 9'd6}, 1'b1, '{RESULT_READ, 10'd0, 8'hDD}}
		};

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i])
			offer_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].expected);

		idling = 1'b1;
		while (sent < RANDOM_TARGET) begin
			if (!done_hold && sent >= 100) begin
				// The result side holds off while reads keep coming, so the block backs up.
				hold_requested = 1'b1;
				repeat (40) send_random_read();
				done_hold = 1'b1;
			end else if (!done_pause && sent >= 150) begin
				wait_for_results();
				done_pause = 1'b1;
			end else if (!done_overflow && sent >= 200) begin
				// Restart the frame, then overrun the whole store by three bytes.
				send_byte(CODE_END);
				for (int i = 0; i < STORE_DEPTH + 3; i++) begin
					b = 8'($urandom_range(0, 255));
					if (b == CODE_END || b == CODE_ESC)
						b = 8'h55;
					send_byte(b);
				end
				send_byte(CODE_END);
				send_read(9'd511);
				send_read(9'd256);
				send_read(9'd0);
				done_overflow = 1'b1;
			end else begin
				case ($urandom_range(0, 9))
					0, 1, 2, 3, 4, 5:
						send_frame(($urandom_range(0, 9) == 0) ?
							$urandom_range(25, 100) : $urandom_range(0, 24));
					6, 7:
						repeat ($urandom_range(1, 4)) send_random_read();
					default:
						send_noise($urandom_range(1, 6));
				endcase
			end
			if ($urandom_range(0, 15) == 0)
				idling = !idling;
		end

		idling = 1'b0;
		quiet_end = sent + QUIET_ITEMS;
		while (sent < quiet_end) begin
			if ($urandom_range(0, 3) == 0)
				send_random_read();
			else
				send_frame($urandom_range(0, 12));
		end

		wait_for_results();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("slip_frame_decoder test passed");
		else
			$display("slip_frame_decoder test failed");
		$finish;
	end

endmodule

@@ slip_frame_decoder.f @@
+incdir+hdl
hdl/sfd_pkg.sv
hdl/sfd_ram.sv
hdl/sfd_front.sv
hdl/sfd_queue.sv
hdl/sfd_back.sv
hdl/slip_frame_decoder.sv
dv/tb_slip_frame_decoder.sv
